FILE: sv/rqd_pkg.sv
// ----------------------------------------------------------------------------
// Ring queue package
// Sizes, status codes, shared types and the ring index helper.
// ----------------------------------------------------------------------------
package rqd_pkg;

  localparam int DEPTH     = 8;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DEDUP  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNDERFLOW   = 2'd2,
    ST_EMPTY_DEDUP = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] popped;
    status_t                     status;
    logic [CNT_W-1:0]            occupancy;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [IDX_W-1:0]     raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: sv/ring_queue_with_dedup_top.sv
// ----------------------------------------------------------------------------
// Ring queue with duplicate removal
// Circular FIFO of signed words with insert, delete and in-place dedup.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// input    in_valid/in_stall    action, value
// output   out_valid/out_stall  popped, status, occupancy
//
// Insert, failed commands and the unused code finish in the idle state.
// Delete goes through a pop state because the ring memory read data is registered.
// Dedup walks the ring and the scratch memory: each entry is read from the ring,
// compared against the kept words in scratch and kept if new, and the kept words
// are then copied back to the ring from slot 0.
// Reset clears the control state, head, count and result valid flags; the memories need no clearing pass.
// A finished result waits in a pending slot while the output is stalled.
// ----------------------------------------------------------------------------
module ring_queue_with_dedup_top
  import rqd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic signed [WORD_BITS-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] popped,
  output logic [1:0]                  status,
  output logic [CNT_W-1:0]            occupancy
);

  mem_req_t             ring_req;
  mem_req_t             scr_req;
  logic [WORD_BITS-1:0] ring_rdata;
  logic [WORD_BITS-1:0] scr_rdata;
  logic                 can_take;
  logic                 res_load;
  res_t                 res;
  res_t                 res_out;

  rqd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .value      (value),
    .can_take   (can_take),
    .res_load   (res_load),
    .res        (res),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata),
    .scr_req    (scr_req),
    .scr_rdata  (scr_rdata)
  );

  rqd_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  rqd_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (scr_req.we),
    .waddr (scr_req.waddr),
    .wdata (scr_req.wdata),
    .raddr (scr_req.raddr),
    .rdata (scr_rdata)
  );

  rqd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign popped    = res_out.popped;
  assign status    = res_out.status;
  assign occupancy = res_out.occupancy;

endmodule

FILE: sv/rqd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rqd_obuf.sv
// ----------------------------------------------------------------------------
// Result buffer
// A pending slot and the output register, so a new transaction can be taken
// while a finished result waits downstream.
// ----------------------------------------------------------------------------
module rqd_obuf
  import rqd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_load,
  input  res_t res,
  output logic can_take,
  output logic out_valid,
  input  logic out_stall,
  output res_t res_out
);

  logic pend_valid;
  res_t pend;
  logic pend_move;

  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign can_take  = !pend_valid || pend_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (res_load) begin
      pend <= res;
    end
    if (pend_move) begin
      res_out <= pend;
    end
  end

endmodule

FILE: sv/rqd_ctrl.sv
// ----------------------------------------------------------------------------
// Queue controller
// Holds head and count, drives the ring and scratch memories, and sequences
// delete reads and the duplicate removal walk.
// ----------------------------------------------------------------------------
module rqd_ctrl
  import rqd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic signed [WORD_BITS-1:0] value,
  input  logic                        can_take,
  output logic                        res_load,
  output res_t                        res,
  output mem_req_t                    ring_req,
  input  logic [WORD_BITS-1:0]        ring_rdata,
  output mem_req_t                    scr_req,
  input  logic [WORD_BITS-1:0]        scr_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_D_RD,
    S_D_GET,
    S_D_CMP,
    S_C_RD,
    S_C_WR
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     head;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     src_i;
  logic [CNT_W-1:0]     cmp_j;
  logic [CNT_W-1:0]     kept_n;
  logic [CNT_W-1:0]     copy_k;
  logic [WORD_BITS-1:0] word;
  logic                 accept;
  logic                 full;
  logic [CNT_W-1:0]     src_i_next;
  logic [CNT_W-1:0]     cmp_j_next;
  logic [CNT_W-1:0]     copy_k_next;

  assign in_stall    = (state != S_IDLE) || !can_take;
  assign accept      = in_valid && !in_stall;
  assign full        = (cnt == CNT_W'(DEPTH));
  assign src_i_next  = src_i + 1'b1;
  assign cmp_j_next  = cmp_j + 1'b1;
  assign copy_k_next = copy_k + 1'b1;

  always_comb begin
    ring_req       = '0;
    scr_req        = '0;
    res_load       = 1'b0;
    res.popped     = '0;
    res.status     = ST_OK;
    res.occupancy  = cnt;
    ring_req.raddr = head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (action)
            ACT_INSERT: begin
              if (full) begin
                res.status = ST_OVERFLOW;
              end else begin
                ring_req.we    = 1'b1;
                ring_req.waddr = slot_of(head, cnt);
                ring_req.wdata = value;
                res.occupancy  = cnt + 1'b1;
              end
            end
            ACT_DELETE: begin
              if (cnt == '0) begin
                res.status = ST_UNDERFLOW;
              end else begin
                res_load = 1'b0;
              end
            end
            ACT_DEDUP: begin
              if (cnt == '0) begin
                res.status = ST_EMPTY_DEDUP;
              end else begin
                res_load = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_load   = 1'b1;
        res.popped = ring_rdata;
      end
      S_D_RD: begin
        ring_req.raddr = slot_of(head, src_i);
      end
      S_D_GET: begin
        if (kept_n == '0) begin
          scr_req.we    = 1'b1;
          scr_req.waddr = '0;
          scr_req.wdata = ring_rdata;
        end
      end
      S_D_CMP: begin
        if (cmp_j_next < kept_n) begin
          scr_req.raddr = cmp_j_next[IDX_W-1:0];
        end
        if ((scr_rdata != word) && (cmp_j_next >= kept_n)) begin
          scr_req.we    = 1'b1;
          scr_req.waddr = kept_n[IDX_W-1:0];
          scr_req.wdata = word;
        end
      end
      S_C_RD: begin
        scr_req.raddr = copy_k[IDX_W-1:0];
      end
      S_C_WR: begin
        ring_req.we    = 1'b1;
        ring_req.waddr = copy_k[IDX_W-1:0];
        ring_req.wdata = scr_rdata;
        if (copy_k_next >= kept_n) begin
          res_load      = 1'b1;
          res.occupancy = kept_n;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      cnt    <= '0;
      src_i  <= '0;
      cmp_j  <= '0;
      kept_n <= '0;
      copy_k <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (action)
              ACT_INSERT: begin
                if (!full) begin
                  cnt <= cnt + 1'b1;
                end
              end
              ACT_DELETE: begin
                if (cnt != '0) begin
                  cnt   <= cnt - 1'b1;
                  head  <= (cnt == CNT_W'(1)) ? '0 : slot_of(head, CNT_W'(1));
                  state <= S_POP;
                end
              end
              ACT_DEDUP: begin
                if (cnt != '0) begin
                  src_i  <= '0;
                  kept_n <= '0;
                  state  <= S_D_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          state <= S_IDLE;
        end
        S_D_RD: begin
          state <= S_D_GET;
        end
        S_D_GET: begin
          word  <= ring_rdata;
          cmp_j <= '0;
          if (kept_n == '0) begin
            kept_n <= CNT_W'(1);
            src_i  <= src_i_next;
            state  <= (src_i_next < cnt) ? S_D_RD : S_C_RD;
            copy_k <= '0;
          end else begin
            state <= S_D_CMP;
          end
        end
        S_D_CMP: begin
          priority if (scr_rdata == word) begin
            src_i  <= src_i_next;
            copy_k <= '0;
            state  <= (src_i_next < cnt) ? S_D_RD : S_C_RD;
          end else if (cmp_j_next < kept_n) begin
            cmp_j <= cmp_j_next;
          end else begin
            kept_n <= kept_n + 1'b1;
            src_i  <= src_i_next;
            copy_k <= '0;
            state  <= (src_i_next < cnt) ? S_D_RD : S_C_RD;
          end
        end
        S_C_RD: begin
          state <= S_C_WR;
        end
        S_C_WR: begin
          if (copy_k_next < kept_n) begin
            copy_k <= copy_k_next;
            state  <= S_C_RD;
          end else begin
            head  <= '0;
            cnt   <= kept_n;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/rqd_check.sv
// ----------------------------------------------------------------------------
// Ring queue port checker
// Checks results seen on the top level ports over time.
// ----------------------------------------------------------------------------
module rqd_check
  import rqd_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [WORD_BITS-1:0] popped,
  input logic [1:0]                  status,
  input logic [CNT_W-1:0]            occupancy
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(popped) && $stable(status)
      && $stable(occupancy))
    else $error("Stalled result transaction changed or vanished.");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OVERFLOW) |-> occupancy == CNT_W'(DEPTH) && popped == '0)
    else $error("Overflow reported while the queue was not full.");

  a_empty_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_UNDERFLOW) || (status == ST_EMPTY_DEDUP))
      |-> occupancy == '0 && popped == '0)
    else $error("Empty-queue status with nonzero occupancy or data.");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(DEPTH))
    else $error("Occupancy beyond the queue depth.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result transaction offered right after reset.");

endmodule

bind ring_queue_with_dedup_top rqd_check u_rqd_check (.*);
